/* src/vga_palette_scanline_generator_core_assert.svh */
// assertion macros for the vga palette scanline generator core
`ifndef VGA_PALETTE_SCANLINE_GENERATOR_CORE_ASSERT_SVH
`define VGA_PALETTE_SCANLINE_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define VPSG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define VPSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/vpsg_pkg.sv */
// package: timing constants, sample levels and color quantization for the scanline generator
package vpsg_pkg;

  localparam int unsigned LineW = 10;
  localparam int unsigned PairW = 9;
  localparam int unsigned SampleW = 8;
  localparam int unsigned IndexW = 8;
  localparam int unsigned RgbW = 24;
  localparam int unsigned EntryW = 16;
  localparam int unsigned PaletteDepth = 256;

  localparam int unsigned LineSamples = 800;
  localparam int unsigned HsyncSamples = 96;
  localparam int unsigned ActiveOffset = 144;
  localparam int unsigned ActiveLines = 480;
  localparam int unsigned TotalLines = 525;
  localparam int unsigned VsyncFirst = 490;
  localparam int unsigned VsyncCount = 2;
  localparam int unsigned SourceWidth = 320;

  localparam logic [PairW-1:0] PairLast = PairW'(LineSamples / 2 - 1);
  localparam logic [PairW-1:0] SyncPairs = PairW'(HsyncSamples / 2);
  localparam logic [PairW-1:0] ActFirst = PairW'(ActiveOffset / 2);
  localparam logic [PairW-1:0] ActEnd = PairW'(ActiveOffset / 2 + SourceWidth);
  localparam logic [LineW-1:0] LineLast = LineW'(TotalLines - 1);
  localparam logic [LineW-1:0] ActLines = LineW'(ActiveLines);
  localparam logic [LineW-1:0] VsFirst = LineW'(VsyncFirst);
  localparam logic [LineW-1:0] VsEnd = LineW'(VsyncFirst + VsyncCount);

  localparam logic [SampleW-1:0] LevelBlank = 8'hc0;
  localparam logic [SampleW-1:0] LevelHsync = 8'h80;
  localparam logic [SampleW-1:0] LevelVsync = 8'h40;
  localparam logic [SampleW-1:0] LevelBothSync = 8'h00;

  // floor(c / 42) for c in 0..255 equals (c * 391) >> 14
  localparam logic [8:0] RecipMul = 9'd391;
  localparam int unsigned RecipShift = 14;

  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_PAL_WRITE = 1'b1
  } req_type_e;

  typedef struct packed {
    logic [LineW-1:0] line;
    logic [PairW-1:0] pair;
    logic swap;
  } pos_t;

  function automatic logic [1:0] level_lookup(input logic [2:0] q, input logic upper);
    logic [1:0] lvl;
    lvl = 2'd0;
    if (upper) begin
      unique case (q)
        3'd0: lvl = 2'd0;
        3'd1: lvl = 2'd1;
        3'd2: lvl = 2'd1;
        3'd3: lvl = 2'd1;
        3'd4: lvl = 2'd2;
        3'd5: lvl = 2'd3;
        3'd6: lvl = 2'd3;
        default: lvl = 2'd3;
      endcase
    end else begin
      unique case (q)
        3'd0: lvl = 2'd0;
        3'd1: lvl = 2'd0;
        3'd2: lvl = 2'd1;
        3'd3: lvl = 2'd2;
        3'd4: lvl = 2'd2;
        3'd5: lvl = 2'd2;
        3'd6: lvl = 2'd3;
        default: lvl = 2'd3;
      endcase
    end
    return lvl;
  endfunction

  function automatic logic [1:0] quantize(input logic [7:0] chan, input logic upper);
    logic [16:0] prod;
    prod = 17'(chan) * 17'(RecipMul);
    return level_lookup(prod[RecipShift+2:RecipShift], upper);
  endfunction

  function automatic logic [SampleW-1:0] encode(input logic [RgbW-1:0] rgb,
                                                input logic upper);
    return {LevelBlank[7:6], quantize(rgb[23:16], upper), quantize(rgb[15:8], upper),
            quantize(rgb[7:0], upper)};
  endfunction

endpackage

/* src/vga_palette_scanline_generator_core.sv */
// top level: vga 640x480 scanline sample generator with dithered palette
// a tick beat is registered in stage one (position and palette read data), then in the output register
// throughput: one beat per cycle while the output is not stalled, ticks and palette writes alike
// palette memory is read and written at the input edge, read data registered
// reset clears counters, frame phase and all palette valid bits; dither comes up on
`include "vga_palette_scanline_generator_core_assert.svh"

module vga_palette_scanline_generator_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         req_type_i,
  input  logic [vpsg_pkg::IndexW-1:0]  pixel_index_i,
  input  logic [vpsg_pkg::IndexW-1:0]  palette_index_i,
  input  logic [vpsg_pkg::RgbW-1:0]    color_rgb_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [vpsg_pkg::SampleW-1:0] left_sample_o,
  output logic [vpsg_pkg::SampleW-1:0] right_sample_o,
  output logic [vpsg_pkg::LineW-1:0]   line_number_o,
  output logic [vpsg_pkg::PairW-1:0]   pair_position_o
);
  import vpsg_pkg::*;

  logic                    dither_q;
  logic [LineW-1:0]        line_count_q, line_count_d;
  logic [PairW-1:0]        pair_count_q, pair_count_d;
  logic                    phase_q, phase_d;

  logic [EntryW-1:0]       palette_mem [PaletteDepth];
  logic [PaletteDepth-1:0] entry_valid_q;
  logic [EntryW-1:0]       rd_data_q;
  logic                    rd_hit_q;

  logic                    s1_valid_q;
  pos_t                    s1_pos_q, s1_pos_d;

  logic                    out_valid_q;
  logic [SampleW-1:0]      left_q, left_d;
  logic [SampleW-1:0]      right_q, right_d;
  logic [LineW-1:0]        line_out_q;
  logic [PairW-1:0]        pair_out_q;

  logic                    accept;
  logic                    tick_acc;
  logic                    wr_acc;
  logic                    s1_move;
  logic [EntryW-1:0]       wr_entry;
  logic [EntryW-1:0]       entry;

  assign s1_move    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_move;
  assign accept     = in_valid_i && in_ready_o;
  assign tick_acc   = accept && (req_type_e'(req_type_i) == REQ_TICK);
  assign wr_acc     = accept && (req_type_e'(req_type_i) == REQ_PAL_WRITE);

  // low byte holds the upper level, high byte the lower level
  assign wr_entry = {encode(color_rgb_i, 1'b0), encode(color_rgb_i, 1'b1)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dither_q <= 1'b1;
    end else if (cfg_we_i) begin
      dither_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    line_count_d = line_count_q;
    pair_count_d = pair_count_q;
    phase_d      = phase_q;
    if (tick_acc) begin
      if (pair_count_q == PairLast) begin
        pair_count_d = '0;
        if (line_count_q == LineLast) begin
          line_count_d = '0;
          phase_d      = !phase_q;
        end else begin
          line_count_d = line_count_q + LineW'(1);
        end
      end else begin
        pair_count_d = pair_count_q + PairW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_count_q <= '0;
      pair_count_q <= '0;
      phase_q      <= 1'b0;
    end else begin
      line_count_q <= line_count_d;
      pair_count_q <= pair_count_d;
      phase_q      <= phase_d;
    end
  end

  // palette memory
  always_ff @(posedge clk_i) begin
    if (wr_acc) begin
      palette_mem[palette_index_i] <= wr_entry;
    end
    if (tick_acc) begin
      rd_data_q <= palette_mem[pixel_index_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= '0;
      rd_hit_q      <= 1'b0;
    end else begin
      if (wr_acc) begin
        entry_valid_q[palette_index_i] <= 1'b1;
      end
      if (tick_acc) begin
        rd_hit_q <= entry_valid_q[pixel_index_i];
      end
    end
  end

  always_comb begin
    s1_pos_d.line = line_count_q;
    s1_pos_d.pair = pair_count_q;
    s1_pos_d.swap = dither_q && (line_count_q[1] ^ phase_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (tick_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      s1_pos_q <= s1_pos_d;
    end
  end

  // sample selection
  assign entry = rd_hit_q ? rd_data_q : '0;

  always_comb begin
    left_d  = LevelBlank;
    right_d = LevelBlank;
    if (s1_pos_q.line < ActLines) begin
      if (s1_pos_q.pair < SyncPairs) begin
        left_d  = LevelHsync;
        right_d = LevelHsync;
      end else if (s1_pos_q.pair >= ActFirst && s1_pos_q.pair < ActEnd) begin
        if (s1_pos_q.swap) begin
          left_d  = entry[15:8];
          right_d = entry[7:0];
        end else begin
          left_d  = entry[7:0];
          right_d = entry[15:8];
        end
      end
    end else if (s1_pos_q.line >= VsFirst && s1_pos_q.line < VsEnd) begin
      left_d  = (s1_pos_q.pair < SyncPairs) ? LevelBothSync : LevelVsync;
      right_d = left_d;
    end else begin
      left_d  = (s1_pos_q.pair < SyncPairs) ? LevelHsync : LevelBlank;
      right_d = left_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      left_q     <= left_d;
      right_q    <= right_d;
      line_out_q <= s1_pos_q.line;
      pair_out_q <= s1_pos_q.pair;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign left_sample_o   = left_q;
  assign right_sample_o  = right_q;
  assign line_number_o   = line_out_q;
  assign pair_position_o = pair_out_q;

  `VPSG_ASSERT_NOW(a_cnt_range, 1'b1,
    (pair_count_q <= PairLast) && (line_count_q <= LineLast), "counter out of range")
  `VPSG_ASSERT_NEXT(a_wr_holds_cnt, wr_acc,
    $stable(pair_count_q) && $stable(line_count_q) && $stable(phase_q),
    "palette write moved counters")
  `VPSG_ASSERT_NEXT(a_s1_drains, s1_valid_q && !out_valid_q, out_valid_q,
    "stage beat not forwarded")
  `VPSG_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(left_sample_o) && $stable(pair_position_o),
    "stalled output beat changed")

endmodule

/* sim/vga_palette_scanline_generator_checker.sv */
`timescale 1ns / 1ps
// checker: scanline sample prediction and output comparison for the generator core
module vga_palette_scanline_generator_checker
  import vpsg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               req_type_i,
  input  logic [IndexW-1:0]  pixel_index_i,
  input  logic [IndexW-1:0]  palette_index_i,
  input  logic [RgbW-1:0]    color_rgb_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [SampleW-1:0] left_sample_i,
  input  logic [SampleW-1:0] right_sample_i,
  input  logic [LineW-1:0]   line_number_i,
  input  logic [PairW-1:0]   pair_position_i,
  output int unsigned        mismatch_count_o,
  output int unsigned        pending_o
);

  localparam int unsigned ChanStep = 42;
  localparam int unsigned PrintCap = 100;

  typedef struct packed {
    logic [SampleW-1:0] left;
    logic [SampleW-1:0] right;
    logic [LineW-1:0]   line;
    logic [PairW-1:0]   pair;
  } sample_pair_t;

  logic [LineW-1:0]  scan_line;
  logic [PairW-1:0]  scan_pair;
  logic              frame_odd;
  logic              dither_on;
  logic [EntryW-1:0] palette_mem [PaletteDepth];
  sample_pair_t      pair_expected_q [$];
  sample_pair_t      got_pair;
  sample_pair_t      want_pair;
  int unsigned       fail_tally;

  function automatic logic [1:0] chan_level(input logic [7:0] chan, input logic upper);
    int unsigned step;
    logic [1:0] lvl;
    step = chan / ChanStep;
    if (upper) begin
      case (step)
        0: lvl = 2'd0;
        1, 2, 3: lvl = 2'd1;
        4: lvl = 2'd2;
        default: lvl = 2'd3;
      endcase
    end else begin
      case (step)
        0, 1: lvl = 2'd0;
        2: lvl = 2'd1;
        3, 4, 5: lvl = 2'd2;
        default: lvl = 2'd3;
      endcase
    end
    return lvl;
  endfunction

  function automatic logic [SampleW-1:0] color_byte(input logic [RgbW-1:0] rgb,
                                                    input logic upper);
    return {LevelBlank[7:6], chan_level(rgb[23:16], upper), chan_level(rgb[15:8], upper),
            chan_level(rgb[7:0], upper)};
  endfunction

  function automatic sample_pair_t predict_pair(input logic [IndexW-1:0] pix);
    sample_pair_t p;
    logic [EntryW-1:0] ent;
    p.line = scan_line;
    p.pair = scan_pair;
    if (scan_line < ActLines) begin
      if (scan_pair < SyncPairs) begin
        p.left = LevelHsync;
        p.right = LevelHsync;
      end else if (scan_pair >= ActFirst && scan_pair < ActEnd) begin
        ent = palette_mem[pix];
        if (dither_on && (scan_line[1] ^ frame_odd)) begin
          p.left = ent[15:8];
          p.right = ent[7:0];
        end else begin
          p.left = ent[7:0];
          p.right = ent[15:8];
        end
      end else begin
        p.left = LevelBlank;
        p.right = LevelBlank;
      end
    end else if (scan_line >= VsFirst && scan_line < VsEnd) begin
      p.left = (scan_pair < SyncPairs) ? LevelBothSync : LevelVsync;
      p.right = p.left;
    end else begin
      p.left = (scan_pair < SyncPairs) ? LevelHsync : LevelBlank;
      p.right = p.left;
    end
    return p;
  endfunction

  task automatic advance_scan();
    if (scan_pair == PairLast) begin
      scan_pair = '0;
      if (scan_line == LineLast) begin
        scan_line = '0;
        frame_odd = ~frame_odd;
      end else begin
        scan_line = scan_line + 1'b1;
      end
    end else begin
      scan_pair = scan_pair + 1'b1;
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (fail_tally < PrintCap) begin
      $display("%0t ns mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
    end
    fail_tally++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_line = '0;
      scan_pair = '0;
      frame_odd = 1'b0;
      dither_on = 1'b1;
      foreach (palette_mem[k]) palette_mem[k] = '0;
      pair_expected_q.delete();
      fail_tally = 0;
      mismatch_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) dither_on = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        if (req_type_i == REQ_PAL_WRITE) begin
          palette_mem[palette_index_i] = {color_byte(color_rgb_i, 1'b0),
                                          color_byte(color_rgb_i, 1'b1)};
        end else begin
          pair_expected_q.push_back(predict_pair(pixel_index_i));
          advance_scan();
        end
      end
      if (out_valid_i && out_ready_i) begin
        got_pair = '{left_sample_i, right_sample_i, line_number_i, pair_position_i};
        if (pair_expected_q.size() == 0) begin
          report_mismatch("beat with nothing expected, line", got_pair.line, 0);
        end else begin
          want_pair = pair_expected_q.pop_front();
          if (got_pair.left !== want_pair.left)
            report_mismatch("left_sample", got_pair.left, want_pair.left);
          if (got_pair.right !== want_pair.right)
            report_mismatch("right_sample", got_pair.right, want_pair.right);
          if (got_pair.line !== want_pair.line)
            report_mismatch("line_number", got_pair.line, want_pair.line);
          if (got_pair.pair !== want_pair.pair)
            report_mismatch("pair_position", got_pair.pair, want_pair.pair);
        end
      end
      mismatch_count_o <= fail_tally;
      pending_o <= pair_expected_q.size();
    end
  end

endmodule

/* sim/tb_vga_palette_scanline_generator_core.sv */
`timescale 1ns / 1ps
// testbench top: stimulus, receiver pacing and verdict for the scanline generator core
module tb_vga_palette_scanline_generator_core;
  import vpsg_pkg::*;

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned LongHold = 300;
  localparam int unsigned LongHoldAt = 200;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_wdata_i = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               req_type_i = REQ_TICK;
  logic [IndexW-1:0]  pixel_index_i = '0;
  logic [IndexW-1:0]  palette_index_i = '0;
  logic [RgbW-1:0]    color_rgb_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [SampleW-1:0] left_sample_o;
  logic [SampleW-1:0] right_sample_o;
  logic [LineW-1:0]   line_number_o;
  logic [PairW-1:0]   pair_position_o;

  int unsigned mismatch_count;
  int unsigned pending;
  logic        idle_on = 1'b1;
  int unsigned rx_beats = 0;
  int unsigned rx_wait = 0;
  int unsigned rx_gap;
  int unsigned quiet_cycles = 0;
  logic [IndexW-1:0] palette_used [$];

  vga_palette_scanline_generator_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .pixel_index_i   (pixel_index_i),
    .palette_index_i (palette_index_i),
    .color_rgb_i     (color_rgb_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .left_sample_o   (left_sample_o),
    .right_sample_o  (right_sample_o),
    .line_number_o   (line_number_o),
    .pair_position_o (pair_position_o)
  );

  vga_palette_scanline_generator_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .req_type_i       (req_type_i),
    .pixel_index_i    (pixel_index_i),
    .palette_index_i  (palette_index_i),
    .color_rgb_i      (color_rgb_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .left_sample_i    (left_sample_o),
    .right_sample_i   (right_sample_o),
    .line_number_i    (line_number_o),
    .pair_position_i  (pair_position_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // output side pacing, with one long hold-off so the block backs up
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      if (rx_wait == 1) out_ready_i <= 1'b1;
    end else if (out_valid_o && out_ready_i) begin
      rx_beats <= rx_beats + 1;
      if (rx_beats == LongHoldAt) rx_gap = LongHold;
      else rx_gap = idle_on ? $urandom_range(0, 4) : 0;
      if (rx_gap != 0) begin
        out_ready_i <= 1'b0;
        rx_wait <= rx_gap;
      end
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("vga_palette_scanline_generator_core verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_beat(input req_type_e kind, input logic [IndexW-1:0] pix,
                           input logic [IndexW-1:0] slot, input logic [RgbW-1:0] rgb);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    pixel_index_i <= pix;
    palette_index_i <= slot;
    color_rgb_i <= rgb;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // drain everything outstanding, then leave room for a palette write in flight
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_dither(input logic value);
    settle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_channel();
    logic [7:0] c;
    if ($urandom_range(0, 1) == 0) begin
      c = 8'($urandom_range(0, 255));
    end else begin
      case ($urandom_range(0, 13))
        0: c = 8'd0;
        1: c = 8'd41;
        2: c = 8'd42;
        3: c = 8'd83;
        4: c = 8'd84;
        5: c = 8'd125;
        6: c = 8'd126;
        7: c = 8'd167;
        8: c = 8'd168;
        9: c = 8'd209;
        10: c = 8'd210;
        11: c = 8'd251;
        12: c = 8'd252;
        default: c = 8'd255;
      endcase
    end
    return c;
  endfunction

  task automatic send_random_item(input int unsigned write_pct);
    logic [IndexW-1:0] pix;
    logic [IndexW-1:0] slot;
    logic [RgbW-1:0] rgb;
    pix = IndexW'($urandom_range(0, 255));
    if (palette_used.size() != 0 && $urandom_range(0, 99) < 70)
      pix = palette_used[$urandom_range(0, palette_used.size() - 1)];
    slot = IndexW'($urandom_range(0, 255));
    rgb = {pick_channel(), pick_channel(), pick_channel()};
    if ($urandom_range(0, 99) < write_pct) begin
      send_beat(REQ_PAL_WRITE, pix, slot, rgb);
      if (palette_used.size() < PaletteDepth) palette_used.push_back(slot);
    end else begin
      send_beat(REQ_TICK, pix, slot, rgb);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_dither(1'b1);
    send_beat(REQ_PAL_WRITE, 8'd0, 8'd0, 24'hffffff);
    send_beat(REQ_PAL_WRITE, 8'd0, 8'd255, 24'h000000);
    send_beat(REQ_PAL_WRITE, 8'd0, 8'd1, 24'h292a2b);
    send_beat(REQ_PAL_WRITE, 8'd0, 8'd2, 24'h53547d);
    send_beat(REQ_PAL_WRITE, 8'd0, 8'd3, 24'h7ea7a8);
    send_beat(REQ_PAL_WRITE, 8'd0, 8'd4, 24'hd1d2fb);
    send_beat(REQ_PAL_WRITE, 8'd0, 8'd5, 24'hfcff00);
    send_beat(REQ_PAL_WRITE, 8'd0, 8'd128, 24'hff0000);
    for (int i = 0; i < 8; i++) palette_used.push_back(i[7:0]);
    palette_used.push_back(8'd255);
    palette_used.push_back(8'd128);
    send_beat(REQ_TICK, 8'd0, 8'd0, 24'h000000);
    send_beat(REQ_TICK, 8'd255, 8'd255, 24'hffffff);
    send_beat(REQ_TICK, 8'd128, 8'd1, 24'h555555);
    send_beat(REQ_TICK, 8'd127, 8'd254, 24'haaaaaa);
    send_beat(REQ_TICK, 8'd77, 8'd9, 24'h123456);
    send_beat(REQ_TICK, 8'd200, 8'd10, 24'hfedcba);

    for (int ph = 0; ph < 4; ph++) begin
      set_dither(ph[0]);
      idle_on = (ph != 2);
      repeat (175) send_random_item(20);
    end

    settle();
    if (mismatch_count == 0 && pending == 0) begin
      $display("vga_palette_scanline_generator_core verification clean");
    end else begin
      $display("vga_palette_scanline_generator_core verification failed");
    end
    $finish;
  end

endmodule
